// ----- rtl/dvr_pkg.sv -----
// Shared types, codes and constants of the distance-vector router node.
// Used by every module of the block; depends on nothing else.
package dvr_pkg;

   localparam int COST_BITS   = 16;
   localparam int DEF_NODES   = 16;
   localparam int DEF_SLOTS   = 16;
   localparam int MAX_RESULTS = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QP_W        = $clog2(QUEUE_DEPTH);
   localparam int HOP_BITS    = 6;

   localparam logic [COST_BITS-1:0] INF_COST = {COST_BITS{1'b1}};
   // Next-hop codes: -2 and -1 in six bits.
   localparam logic [HOP_BITS-1:0]  HOP_SELF = 6'h3E;
   localparam logic [HOP_BITS-1:0]  HOP_NONE = 6'h3F;

   // Input operation codes; the last one has no meaning and is ignored.
   localparam logic [1:0] OP_EDGE   = 2'd0;
   localparam logic [1:0] OP_VECTOR = 2'd1;
   localparam logic [1:0] OP_DUMP   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Reply mode codes of an edge set; the last one behaves as no reply.
   localparam logic [1:0] MODE_ECHO   = 2'd0;
   localparam logic [1:0] MODE_VECTOR = 2'd1;
   localparam logic [1:0] MODE_NONE   = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // Result kinds.
   localparam logic [1:0] KIND_EDGE   = 2'd0;
   localparam logic [1:0] KIND_VECTOR = 2'd1;
   localparam logic [1:0] KIND_DUMP   = 2'd2;

   // Route kinds.
   localparam logic [1:0] ROUTE_VIA  = 2'd0;
   localparam logic [1:0] ROUTE_SELF = 2'd1;
   localparam logic [1:0] ROUTE_NONE = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [3:0]  neighbor;
      logic [15:0] edge_cost;
      logic [1:0]  reply_mode;
      logic [3:0]  dest_index;
      logic [15:0] distance;
      logic        last_element;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  peer;
      logic [15:0] amount;
      logic [3:0]  route_dest;
      logic [3:0]  hop_slot;
      logic [1:0]  route_kind;
      logic        last_result;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_EDGE,
      CMD_VECTOR,
      CMD_DUMP,
      CMD_IGNORE
   } cmd_kind_type;

   typedef enum logic [1:0] {
      RPL_ECHO,
      RPL_VECTOR,
      RPL_NONE
   } reply_type;

   // A classified transaction as it waits in the queue.
   typedef struct packed {
      cmd_kind_type         kind;
      reply_type            reply;
      logic [3:0]           neighbor;
      logic [COST_BITS-1:0] cost;
      logic [3:0]           dest;
      logic [COST_BITS-1:0] distance;
      logic                 last;
   } cmd_type;

endpackage

// ----- rtl/distance_vector_router_node_unit.sv -----
// Top level of the distance-vector router node: node id register, front end and back end.
// Depends on dvr_pkg, dvr_front and dvr_back.
//
//   channel   ports                          handshake
//   request   start, busy, req_data          taken when start high and busy low
//   result    rsp_strobe, rsp_data           high for a single cycle per result, cannot be held off
//   register  csr_valid, csr_ready, csr_data written when valid and ready
//
// Two requests can wait in the queue; busy rises when it is full.
// Edge set: slot search, clearing of a found or free slot's vector one destination at a time,
// then a reply or a broadcast of up to 16 results. Vector element: slot search, and on
// the last element from a known neighbour a recompute through the vector memory port.
// Dump: up to 16 results. Synchronous reset; no clearing pass is needed.
module distance_vector_router_node_unit
   import dvr_pkg::*;
#(
   parameter int NODES = DEF_NODES,
   parameter int SLOTS = DEF_SLOTS
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_strobe,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_data
);

   logic       q_valid;
   logic       q_pop;
   cmd_type    q_head;
   logic [3:0] node_id_ff;

   assign csr_ready = 1'b1;

   // Node id register.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         node_id_ff <= csr_data;
      end
   end

   dvr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .q_valid  (q_valid),
      .q_head   (q_head),
      .q_pop    (q_pop)
   );

   dvr_back #(
      .NODES (NODES),
      .SLOTS (SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .node_id    (node_id_ff),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- rtl/dvr_front.sv -----
// Front end: accepts request transactions, classifies them and queues them.
// Depends on dvr_pkg.
module dvr_front
   import dvr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    q_valid,
   output cmd_type q_head,
   input  logic    q_pop
);

   cmd_type              cmd_cl;
   cmd_type              entry_ff [QUEUE_DEPTH];
   logic [QP_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QP_W:0]        count_ff, count_in;
   logic                 push;

   // Classify the operation and the reply mode; unknown codes fall to the safe choice.
   always_comb begin
      cmd_cl.neighbor = req_data.neighbor;
      cmd_cl.cost     = req_data.edge_cost;
      cmd_cl.dest     = req_data.dest_index;
      cmd_cl.distance = req_data.distance;
      cmd_cl.last     = req_data.last_element;
      unique case (req_data.operation)
         OP_EDGE:   cmd_cl.kind = CMD_EDGE;
         OP_VECTOR: cmd_cl.kind = CMD_VECTOR;
         OP_DUMP:   cmd_cl.kind = CMD_DUMP;
         default:   cmd_cl.kind = CMD_IGNORE;
      endcase
      unique case (req_data.reply_mode)
         MODE_ECHO:   cmd_cl.reply = RPL_ECHO;
         MODE_VECTOR: cmd_cl.reply = RPL_VECTOR;
         default:     cmd_cl.reply = RPL_NONE;
      endcase
   end

   assign busy    = (count_ff == (QP_W+1)'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_head  = entry_ff[rd_ptr_ff];
   // Transactions that do nothing are dropped here and never queued.
   assign push    = start && !busy && (cmd_cl.kind != CMD_IGNORE);

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = (q_pop && q_valid) ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !(q_pop && q_valid)) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop && q_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd_cl;
      end
   end

endmodule

// ----- rtl/dvr_back.sv -----
// Back end: slot table, neighbour vectors, route recompute and result output.
// Depends on dvr_pkg.
module dvr_back
   import dvr_pkg::*;
#(
   parameter int NODES = DEF_NODES,
   parameter int SLOTS = DEF_SLOTS
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic [3:0] node_id,
   input  logic       q_valid,
   input  cmd_type    q_head,
   output logic       q_pop,
   output logic       rsp_strobe,
   output rsp_type    rsp_data
);

   localparam int NODE_W   = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W    = $clog2(SLOTS + 1);
   localparam int NV_AW    = SLOT_W + NODE_W;
   localparam int NV_DEPTH = 2 ** NV_AW;
   localparam int EMIT_N   = (NODES < MAX_RESULTS) ? NODES : MAX_RESULTS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_CLEAR,
      ST_REPLY,
      ST_RECOMP,
      ST_EMIT
   } state_type;

   // Memories.
   logic [3:0]           nbr_mem  [SLOTS];
   logic [COST_BITS-1:0] cost_mem [SLOTS];
   logic [COST_BITS-1:0] nv_mem   [NV_DEPTH];
   logic [COST_BITS-1:0] od_mem   [NODES];
   logic [HOP_BITS-1:0]  oh_mem   [NODES];
   logic [NODES-1:0]     ov_ff, ov_in;

   // Registered read data.
   logic [3:0]           nbr_rd_ff;
   logic [COST_BITS-1:0] cost_rd_ff, nv_rd_ff, od_rd_ff;
   logic [HOP_BITS-1:0]  oh_rd_ff;
   logic                 ov_rd_ff;

   // Read addresses and write ports.
   logic [SLOT_W-1:0]    slot_ra;
   logic [NV_AW-1:0]     nv_ra, nv_wa;
   logic [NODE_W-1:0]    own_ra, own_wa;
   logic                 slot_we, nv_we, own_we;
   logic [SLOT_W-1:0]    slot_wa;
   logic [COST_BITS-1:0] nv_wd, od_wd;
   logic [HOP_BITS-1:0]  oh_wd;

   // Control and pipeline registers.
   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SLOTS-1:0]     live_ff, live_in;
   logic [CNT_W-1:0]     sj_ff, sj_in;
   logic                 chk_go_ff, chk_go_in;
   logic                 chk_v_ff, chk_v_in;
   logic [SLOT_W-1:0]    chk_j_ff, chk_j_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [NODE_W-1:0]    ci_ff, ci_in;
   logic [NODE_W-1:0]    ri_ff, ri_in;
   logic [SLOT_W-1:0]    rj_ff, rj_in;
   logic                 iss_ff, iss_in;
   logic                 p_v_ff, p_v_in;
   logic [NODE_W-1:0]    p_i_ff, p_i_in;
   logic [SLOT_W-1:0]    p_j_ff, p_j_in;
   logic                 p_in_ff, p_in_in;
   logic                 p_first_ff, p_first_in;
   logic                 p_last_ff, p_last_in;
   logic                 p_end_ff, p_end_in;
   logic [COST_BITS-1:0] acc_best_ff, acc_best_in;
   logic [HOP_BITS-1:0]  acc_hop_ff, acc_hop_in;
   logic                 changed_ff, changed_in;
   logic [NODE_W-1:0]    e_ff, e_in;
   logic                 e_iss_ff, e_iss_in;
   logic                 ev_ff, ev_in;
   logic [NODE_W-1:0]    e_d_ff, e_d_in;
   logic                 e_last_ff, e_last_in;
   logic [1:0]           emit_kind_ff, emit_kind_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;

   // Combinational helpers.
   logic                 any_live;
   logic                 found;
   logic [COST_BITS:0]   sum;
   logic [COST_BITS-1:0] sat, base_best, new_best, old_best;
   logic [HOP_BITS-1:0]  base_hop, new_hop, old_hop;
   logic                 self_row, row_changed;
   logic [1:0]           out_rk;

   assign any_live   = |live_ff;
   assign q_pop      = (state_ff == ST_IDLE) && q_valid;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Saturating add and strict minimum for the entry in the second recompute stage.
   always_comb begin
      sum       = {1'b0, nv_rd_ff} + {1'b0, cost_rd_ff};
      sat       = (sum >= {1'b0, INF_COST}) ? INF_COST : sum[COST_BITS-1:0];
      self_row  = (8'(p_i_ff) == 8'(node_id));
      base_best = p_first_ff ? (self_row ? '0 : INF_COST) : acc_best_ff;
      base_hop  = p_first_ff ? (self_row ? HOP_SELF : HOP_NONE) : acc_hop_ff;
      if (p_in_ff && (cost_rd_ff != INF_COST) && (sat < base_best)) begin
         new_best = sat;
         new_hop  = HOP_BITS'(p_j_ff);
      end else begin
         new_best = base_best;
         new_hop  = base_hop;
      end
      old_best    = ov_rd_ff ? od_rd_ff : INF_COST;
      old_hop     = ov_rd_ff ? oh_rd_ff : HOP_NONE;
      row_changed = (new_best != old_best) || (new_hop != old_hop);
      priority if (old_hop == HOP_SELF) begin
         out_rk = ROUTE_SELF;
      end else if (old_hop == HOP_NONE) begin
         out_rk = ROUTE_NONE;
      end else begin
         out_rk = ROUTE_VIA;
      end
   end

   assign found = chk_v_ff && (nbr_rd_ff == cmd_ff.neighbor);

   // Sequencer: next state and all register updates.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      count_in      = count_ff;
      live_in       = live_ff;
      sj_in         = sj_ff;
      chk_go_in     = chk_go_ff;
      chk_v_in      = chk_v_ff;
      chk_j_in      = chk_j_ff;
      slot_in       = slot_ff;
      ci_in         = ci_ff;
      ri_in         = ri_ff;
      rj_in         = rj_ff;
      iss_in        = iss_ff;
      p_v_in        = 1'b0;
      p_i_in        = p_i_ff;
      p_j_in        = p_j_ff;
      p_in_in       = p_in_ff;
      p_first_in    = p_first_ff;
      p_last_in     = p_last_ff;
      p_end_in      = p_end_ff;
      acc_best_in   = acc_best_ff;
      acc_hop_in    = acc_hop_ff;
      changed_in    = changed_ff;
      e_in          = e_ff;
      e_iss_in      = e_iss_ff;
      ev_in         = 1'b0;
      e_d_in        = e_d_ff;
      e_last_in     = e_last_ff;
      emit_kind_in  = emit_kind_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ov_in         = ov_ff;
      slot_we       = 1'b0;
      slot_wa       = chk_j_ff;
      nv_we         = 1'b0;
      nv_wa         = {slot_ff, ci_ff};
      nv_wd         = INF_COST;
      own_we        = 1'b0;
      own_wa        = p_i_ff;
      od_wd         = new_best;
      oh_wd         = new_hop;
      slot_ra       = (state_ff == ST_SEARCH) ? sj_ff[SLOT_W-1:0] : rj_ff;
      nv_ra         = {rj_ff, ri_ff};
      own_ra        = (state_ff == ST_EMIT) ? e_ff : ri_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cmd_in    = q_head;
               sj_in     = '0;
               chk_go_in = 1'b0;
               unique case (q_head.kind)
                  CMD_EDGE, CMD_VECTOR: begin
                     state_in = ST_SEARCH;
                  end
                  CMD_DUMP: begin
                     emit_kind_in = KIND_DUMP;
                     e_in         = '0;
                     e_iss_in     = 1'b1;
                     state_in     = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // Walk the slots one a cycle; the compare runs in the cycle after the read.
         ST_SEARCH: begin
            chk_v_in  = (sj_ff < count_ff);
            chk_j_in  = sj_ff[SLOT_W-1:0];
            chk_go_in = 1'b1;
            if (sj_ff < count_ff) begin
               sj_in = sj_ff + 1'b1;
            end
            if (chk_go_ff && (found || !chk_v_ff)) begin
               if (cmd_ff.kind == CMD_EDGE) begin
                  if (found || (count_ff < CNT_W'(SLOTS))) begin
                     slot_wa = found ? chk_j_ff : count_ff[SLOT_W-1:0];
                     slot_we = 1'b1;
                     slot_in = slot_wa;
                     live_in[slot_wa] = (cmd_ff.cost != INF_COST);
                     if (!found) begin
                        count_in = count_ff + 1'b1;
                     end
                     ci_in    = '0;
                     state_in = ST_CLEAR;
                  end else begin
                     state_in = ST_REPLY;
                  end
               end else if (found) begin
                  if (int'(cmd_ff.dest) < NODES) begin
                     nv_we = 1'b1;
                     nv_wa = {chk_j_ff, NODE_W'(cmd_ff.dest)};
                     nv_wd = cmd_ff.distance;
                  end
                  if (cmd_ff.last) begin
                     ri_in      = '0;
                     rj_in      = '0;
                     iss_in     = 1'b1;
                     changed_in = 1'b0;
                     state_in   = ST_RECOMP;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         // Reset the slot's stored vector to infinity, one destination a cycle.
         ST_CLEAR: begin
            nv_we = 1'b1;
            if (ci_ff == NODE_W'(NODES - 1)) begin
               state_in = ST_REPLY;
            end else begin
               ci_in = ci_ff + 1'b1;
            end
         end

         ST_REPLY: begin
            unique case (cmd_ff.reply)
               RPL_ECHO: begin
                  rsp_in.kind        = KIND_EDGE;
                  rsp_in.peer        = cmd_ff.neighbor;
                  rsp_in.amount      = cmd_ff.cost;
                  rsp_in.route_dest  = '0;
                  rsp_in.hop_slot    = '0;
                  rsp_in.route_kind  = ROUTE_VIA;
                  rsp_in.last_result = 1'b1;
                  rsp_strobe_in      = 1'b1;
                  state_in           = ST_IDLE;
               end
               RPL_VECTOR: begin
                  if (any_live) begin
                     emit_kind_in = KIND_VECTOR;
                     e_in         = '0;
                     e_iss_in     = 1'b1;
                     state_in     = ST_EMIT;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         // Two-stage walk over every destination and slot.
         ST_RECOMP: begin
            if (iss_ff) begin
               p_v_in     = 1'b1;
               p_i_in     = ri_ff;
               p_j_in     = rj_ff;
               p_in_in    = (CNT_W'(rj_ff) < count_ff);
               p_first_in = (rj_ff == '0);
               p_last_in  = (rj_ff == SLOT_W'(SLOTS - 1));
               p_end_in   = (rj_ff == SLOT_W'(SLOTS - 1)) && (ri_ff == NODE_W'(NODES - 1));
               if (rj_ff == SLOT_W'(SLOTS - 1)) begin
                  rj_in = '0;
                  if (ri_ff == NODE_W'(NODES - 1)) begin
                     iss_in = 1'b0;
                  end else begin
                     ri_in = ri_ff + 1'b1;
                  end
               end else begin
                  rj_in = rj_ff + 1'b1;
               end
            end
            if (p_v_ff) begin
               acc_best_in = new_best;
               acc_hop_in  = new_hop;
               if (p_last_ff) begin
                  own_we         = 1'b1;
                  ov_in[p_i_ff]  = 1'b1;
                  if (row_changed) begin
                     changed_in = 1'b1;
                  end
               end
               if (p_end_ff) begin
                  if ((changed_ff || row_changed) && any_live) begin
                     emit_kind_in = KIND_VECTOR;
                     e_in         = '0;
                     e_iss_in     = 1'b1;
                     state_in     = ST_EMIT;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end

         // Read the own table one destination a cycle and present each entry.
         ST_EMIT: begin
            if (e_iss_ff) begin
               ev_in     = 1'b1;
               e_d_in    = e_ff;
               e_last_in = (e_ff == NODE_W'(EMIT_N - 1));
               if (e_ff == NODE_W'(EMIT_N - 1)) begin
                  e_iss_in = 1'b0;
               end else begin
                  e_in = e_ff + 1'b1;
               end
            end
            if (ev_ff) begin
               rsp_in.kind        = emit_kind_ff;
               rsp_in.peer        = '0;
               rsp_in.amount      = old_best;
               rsp_in.route_dest  = 4'(e_d_ff);
               rsp_in.hop_slot    = (out_rk == ROUTE_VIA) ? old_hop[3:0] : 4'd0;
               rsp_in.route_kind  = out_rk;
               rsp_in.last_result = e_last_ff;
               rsp_strobe_in      = 1'b1;
               if (e_last_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         live_ff       <= '0;
         ov_ff         <= '0;
         chk_go_ff     <= 1'b0;
         iss_ff        <= 1'b0;
         p_v_ff        <= 1'b0;
         e_iss_ff      <= 1'b0;
         ev_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         changed_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         live_ff       <= live_in;
         ov_ff         <= ov_in;
         chk_go_ff     <= chk_go_in;
         iss_ff        <= iss_in;
         p_v_ff        <= p_v_in;
         e_iss_ff      <= e_iss_in;
         ev_ff         <= ev_in;
         rsp_strobe_ff <= rsp_strobe_in;
         changed_ff    <= changed_in;
      end
      cmd_ff       <= cmd_in;
      sj_ff        <= sj_in;
      chk_v_ff     <= chk_v_in;
      chk_j_ff     <= chk_j_in;
      slot_ff      <= slot_in;
      ci_ff        <= ci_in;
      ri_ff        <= ri_in;
      rj_ff        <= rj_in;
      p_i_ff       <= p_i_in;
      p_j_ff       <= p_j_in;
      p_in_ff      <= p_in_in;
      p_first_ff   <= p_first_in;
      p_last_ff    <= p_last_in;
      p_end_ff     <= p_end_in;
      acc_best_ff  <= acc_best_in;
      acc_hop_ff   <= acc_hop_in;
      e_ff         <= e_in;
      e_d_ff       <= e_d_in;
      e_last_ff    <= e_last_in;
      emit_kind_ff <= emit_kind_in;
      rsp_ff       <= rsp_in;
   end

   // Memory writes and registered reads.
   always_ff @(posedge clock) begin
      if (slot_we) begin
         nbr_mem[slot_wa]  <= cmd_ff.neighbor;
         cost_mem[slot_wa] <= cmd_ff.cost;
      end
      if (nv_we) begin
         nv_mem[nv_wa] <= nv_wd;
      end
      if (own_we) begin
         od_mem[own_wa] <= od_wd;
         oh_mem[own_wa] <= oh_wd;
      end
      nbr_rd_ff  <= nbr_mem[slot_ra];
      cost_rd_ff <= cost_mem[slot_ra];
      nv_rd_ff   <= nv_mem[nv_ra];
      od_rd_ff   <= od_mem[own_ra];
      oh_rd_ff   <= oh_mem[own_ra];
      ov_rd_ff   <= ov_ff[own_ra];
   end

endmodule

// ----- rtl/dvr_checker.sv -----
// Port-level checks on the router node, bound to the top level.
// Depends on dvr_pkg and distance_vector_router_node_unit.
module dvr_checker
   import dvr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // No result and busy low straight after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe && !busy)
      else $error("result or busy right after reset");

   // An edge reply is always a single, final result.
   a_edge_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.kind == KIND_EDGE |-> rsp_data.last_result)
      else $error("edge reply not marked last");

   // The route to itself costs nothing.
   a_self_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.kind != KIND_EDGE && rsp_data.route_kind == ROUTE_SELF
      |-> rsp_data.amount == '0)
      else $error("self route with non-zero distance");

   // An unreachable entry carries infinity and no hop.
   a_none_inf: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.kind != KIND_EDGE && rsp_data.route_kind == ROUTE_NONE
      |-> rsp_data.amount == INF_COST && rsp_data.hop_slot == '0)
      else $error("unreachable entry with finite distance or a hop");

endmodule

bind distance_vector_router_node_unit dvr_checker u_dvr_checker (.*);

// ----- sim/dvr_checker.sv -----
// Checker of the distance-vector router node: follows the request, result and register
// channels, predicts every result and compares it field by field. Depends on dvr_pkg.
`timescale 1ns / 100ps
module dvr_monitor
   import dvr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  req_type    req_data,
   input  logic       rsp_strobe,
   input  rsp_type    rsp_data,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [3:0] csr_data,
   output int         fail_count,
   output int         pending_routes
);

   // Shadow copy of the node's routing state.
   logic [3:0]           own_id;
   int                   n_slots;
   logic [3:0]           nbr_of [16];
   logic [COST_BITS-1:0] cost_of [16];
   logic [COST_BITS-1:0] heard [16][16];
   logic [COST_BITS-1:0] best_dist [16];
   logic [HOP_BITS-1:0]  best_hop [16];
   rsp_type              route_queue [$];

   function automatic int slot_of(input logic [3:0] nb);
      for (int j = 0; j < n_slots; j++)
         if (nbr_of[j] == nb) return j;
      return -1;
   endfunction

   function automatic bit has_live_link();
      for (int j = 0; j < n_slots; j++)
         if (cost_of[j] != INF_COST) return 1;
      return 0;
   endfunction

   // Bellman-Ford relaxation over the live slots; returns whether anything moved.
   function automatic bit relax_routes();
      logic [COST_BITS:0]   sum;
      logic [COST_BITS-1:0] b;
      logic [HOP_BITS-1:0]  h;
      bit                   moved;
      moved = 0;
      for (int i = 0; i < 16; i++) begin
         b = INF_COST;
         h = HOP_NONE;
         if (i == own_id) begin
            b = '0;
            h = HOP_SELF;
         end
         for (int j = 0; j < n_slots; j++) begin
            if (cost_of[j] == INF_COST) continue;
            sum = {1'b0, heard[j][i]} + {1'b0, cost_of[j]};
            if (sum > INF_COST) sum = INF_COST;
            if (sum < b) begin
               b = sum[COST_BITS-1:0];
               h = HOP_BITS'(j);
            end
         end
         if (b != best_dist[i] || h != best_hop[i]) moved = 1;
         best_dist[i] = b;
         best_hop[i]  = h;
      end
      return moved;
   endfunction

   function automatic void push_table(input logic [1:0] k);
      rsp_type r;
      for (int d = 0; d < 16; d++) begin
         r = '0;
         r.kind       = k;
         r.amount     = best_dist[d];
         r.route_dest = 4'(d);
         if (best_hop[d] == HOP_SELF) r.route_kind = ROUTE_SELF;
         else if (best_hop[d] == HOP_NONE) r.route_kind = ROUTE_NONE;
         else begin
            r.route_kind = ROUTE_VIA;
            r.hop_slot   = best_hop[d][3:0];
         end
         r.last_result = (d == 15);
         route_queue.push_back(r);
      end
   endfunction

   function automatic void predict(input req_type q);
      int      s;
      rsp_type r;
      case (q.operation)
         OP_EDGE: begin
            s = slot_of(q.neighbor);
            if (s < 0 && n_slots < 16) begin
               s = n_slots;
               n_slots++;
            end
            if (s >= 0) begin
               nbr_of[s]  = q.neighbor;
               cost_of[s] = q.edge_cost;
               for (int i = 0; i < 16; i++) heard[s][i] = INF_COST;
            end
            if (q.reply_mode == MODE_ECHO) begin
               r = '0;
               r.kind        = KIND_EDGE;
               r.peer        = q.neighbor;
               r.amount      = q.edge_cost;
               r.last_result = 1'b1;
               route_queue.push_back(r);
            end else if (q.reply_mode == MODE_VECTOR && has_live_link())
               push_table(KIND_VECTOR);
         end
         OP_VECTOR: begin
            s = slot_of(q.neighbor);
            if (s >= 0) begin
               heard[s][q.dest_index] = q.distance;
               if (q.last_element && relax_routes() && has_live_link())
                  push_table(KIND_VECTOR);
            end
         end
         OP_DUMP: push_table(KIND_DUMP);
         default: ;
      endcase
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Observe every transaction at the clock edge that accepts it.
   always @(posedge clock) begin
      rsp_type w;
      if (reset) begin
         own_id  = '0;
         n_slots = 0;
         for (int j = 0; j < 16; j++)
            for (int i = 0; i < 16; i++) heard[j][i] = INF_COST;
         for (int i = 0; i < 16; i++) begin
            best_dist[i] = INF_COST;
            best_hop[i]  = HOP_NONE;
         end
         route_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (route_queue.size() == 0) begin
               $error("result with no transaction waiting for it");
               fail_count++;
            end else begin
               w = route_queue.pop_front();
               check_field("kind", w.kind, rsp_data.kind);
               check_field("peer", w.peer, rsp_data.peer);
               check_field("amount", w.amount, rsp_data.amount);
               check_field("route_dest", w.route_dest, rsp_data.route_dest);
               check_field("hop_slot", w.hop_slot, rsp_data.hop_slot);
               check_field("route_kind", w.route_kind, rsp_data.route_kind);
               check_field("last_result", w.last_result, rsp_data.last_result);
            end
         end
         if (start && !busy) predict(req_data);
         if (csr_valid && csr_ready) own_id = csr_data;
      end
      pending_routes = route_queue.size();
   end

endmodule

// ----- sim/tb.sv -----
// Testbench top of the distance-vector router node: clock, reset, stimulus and verdict.
// Depends on dvr_pkg, distance_vector_router_node_unit and dvr_monitor.
`timescale 1ns / 100ps
module tb;
   import dvr_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int REQ_W       = $bits(req_type);

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [3:0] csr_data;
   int         fail_count;
   int         pending_routes;
   int         quiet_cycles;
   bit         calm;
   logic [3:0] known_nbrs [$];

   distance_vector_router_node_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   dvr_monitor u_monitor (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data), .fail_count(fail_count),
      .pending_routes(pending_routes)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("** distance_vector_router_node_unit: FAILED **");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // Start stays high from one transaction to the next unless the sender idles.
   task automatic send(input req_type q);
      if (!calm && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_routes != 0) @(posedge clock);
      // Work that makes no result may still be in flight: allow for a full queue of
      // recomputes.
      repeat (1000) @(posedge clock);
   endtask

   task automatic write_id(input logic [3:0] id);
      csr_valid <= 1'b1;
      csr_data  <= id;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type make_op(input logic [1:0] op, input logic [3:0] nb,
                                       input logic [15:0] c, input logic [1:0] m,
                                       input logic [3:0] d, input logic [15:0] dval,
                                       input logic l);
      req_type q;
      q.operation = op; q.neighbor = nb; q.edge_cost = c; q.reply_mode = m;
      q.dest_index = d; q.distance = dval; q.last_element = l;
      return q;
   endfunction

   function automatic logic [15:0] pick_cost();
      case ($urandom_range(0, 5))
         0: return INF_COST;
         1: return 16'hFFFE;
         2: return 16'h0000;
         3: return 16'($urandom());
         default: return 16'($urandom_range(1, 40));
      endcase
   endfunction

   // One random item: mostly a short run of neighbour vector elements from known routers.
   task automatic random_item();
      req_type     q;
      logic [3:0]  nb;
      int          roll;
      int          n;
      roll = $urandom_range(0, 99);
      q = REQ_W'({$urandom(), $urandom()});
      nb = (known_nbrs.size() != 0 && $urandom_range(0, 9) != 0) ?
           known_nbrs[$urandom_range(0, known_nbrs.size() - 1)] : 4'($urandom());
      if (roll < 20) begin
         q = make_op(OP_EDGE, 4'($urandom()), pick_cost(), 2'($urandom()),
                     4'($urandom()), 16'($urandom()), 1'($urandom()));
         known_nbrs.push_back(q.neighbor);
      end else if (roll < 28)
         q.operation = OP_DUMP;
      else if (roll < 31)
         q.operation = OP_UNUSED;
      else begin
         // A short run of vector elements with random content, sometimes cut short.
         n = $urandom_range(1, 4);
         for (int e = 0; e < n; e++) begin
            send(make_op(OP_VECTOR, nb, 16'($urandom()), 2'($urandom()), 4'($urandom()),
                         pick_cost(), e == n - 1 || $urandom_range(0, 30) == 0));
            if ($urandom_range(0, 40) == 0) break;
         end
         return;
      end
      send(q);
   endtask

   initial begin
      start = 0; req_data = '0; csr_valid = 0; csr_data = '0; calm = 0;
      reset = 1;
      repeat (2) @(posedge clock);
      reset <= 0;

      // Directed: extremes, every operation and reply mode, special cases.
      write_id(4'd0);
      send(make_op(OP_DUMP, 0, 0, 0, 0, 0, 0));
      send(make_op(OP_EDGE, 4'd3, 16'd5, MODE_VECTOR, 0, 0, 0));
      send(make_op(OP_VECTOR, 4'd9, 0, 0, 4'd1, 16'd1, 1));
      send(make_op(OP_VECTOR, 4'd3, 0, 0, 4'd7, 16'd2, 0));
      send(make_op(OP_VECTOR, 4'd3, 0, 0, 4'd15, 16'hFFFA, 1));
      send(make_op(OP_EDGE, 4'd15, 16'hFFFF, MODE_ECHO, 4'hF, 16'hFFFF, 1));
      send(make_op(OP_EDGE, 4'd15, 16'h0000, MODE_UNUSED, 0, 0, 0));
      send(make_op(OP_EDGE, 4'd4, 16'hFFFE, MODE_VECTOR, 0, 0, 0));
      send(make_op(OP_VECTOR, 4'd4, 0, 0, 4'd2, 16'h0001, 1));
      send(make_op(OP_VECTOR, 4'd15, 0, 0, 4'd7, 16'd0, 1));
      send(make_op(OP_UNUSED, 4'hF, 16'hFFFF, MODE_UNUSED, 4'hF, 16'hFFFF, 1));
      send(make_op(OP_EDGE, 4'd3, 16'hFFFF, MODE_NONE, 0, 0, 0));
      send(make_op(OP_DUMP, 4'hF, 16'hFFFF, MODE_UNUSED, 4'hF, 16'hFFFF, 1));
      // Fill the table, then set an edge whose neighbour is already in it, with an echo.
      for (int k = 0; k < 14; k++)
         send(make_op(OP_EDGE, 4'(k + 5), 16'(k + 1), MODE_NONE, 0, 0, 0));
      send(make_op(OP_EDGE, 4'd0, 16'd1, MODE_ECHO, 0, 0, 0));
      send(make_op(OP_DUMP, 0, 0, 0, 0, 0, 0));
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         write_id(phase == 0 ? 4'd15 : phase == 1 ? 4'd7 : 4'($urandom()));
         for (int k = 0; k < 12; k++) begin
            calm = (phase == 3 && k > 5);
            random_item();
            // Let everything settle once, with no request outstanding.
            if (phase == 1 && k == 5) begin
               start <= 1'b0;
               @(posedge clock);
               while (pending_routes != 0) @(posedge clock);
            end
         end
         send(make_op(OP_DUMP, 0, 0, 0, 0, 0, 0));
         drain();
      end

      if (fail_count == 0)
         $display("** distance_vector_router_node_unit: PASSED **");
      else
         $display("** distance_vector_router_node_unit: FAILED **");
      $finish;
   end

endmodule
